>>> rtl/core/lpk_pkg.sv
`timescale 1ns / 1ps
// lpk_pkg: types and constants shared by the leading particle kinematics block
// no dependencies
package lpk_pkg;

    localparam int NUM_CLASSES = 4;
    localparam int CLS_W       = 2;
    localparam int COS_FRAC    = 14;
    localparam logic [31:0] CODE_ELECTRON = 32'd11;
    localparam logic [31:0] CODE_MUON     = 32'd13;
    localparam logic [31:0] CODE_PHOTON   = 32'd22;
    localparam logic [CLS_W-1:0] CLS_ELECTRON = 2'd0;
    localparam logic [CLS_W-1:0] CLS_MUON     = 2'd1;
    localparam logic [CLS_W-1:0] CLS_PHOTON   = 2'd2;
    localparam logic [CLS_W-1:0] CLS_ANY      = 2'd3;
    localparam logic signed [15:0] COS_ONE     = 16'sd16384;
    localparam logic signed [15:0] COS_NEG_ONE = -16'sd16384;

    typedef struct packed {
        logic [31:0]        energy;
        logic signed [31:0] mom_x;
        logic signed [31:0] mom_y;
        logic signed [31:0] mom_z;
        logic signed [31:0] particle_code;
        logic               last_of_event;
    } particle_t;

    typedef struct packed {
        logic [1:0]         category;
        logic               found;
        logic [31:0]        best_energy_out;
        logic [31:0]        total_momentum;
        logic [31:0]        transverse_momentum;
        logic signed [15:0] cos_theta;
        logic signed [31:0] code_out;
        logic               last_result;
    } result_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] energy;
        logic [31:0] mom_x;
        logic [31:0] mom_y;
        logic [31:0] mom_z;
        logic [31:0] code;
    } class_entry_t;

    typedef class_entry_t [NUM_CLASSES-1:0] event_snap_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MUL,
        B_PT_INIT,
        B_PT_STEP,
        B_P_INIT,
        B_P_STEP,
        B_DIV_INIT,
        B_DIV_STEP,
        B_EMIT
    } back_state_t;

    // magnitude on 32 bits, -2^31 maps to 2^31
    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? (~v + 32'd1) : v;
    endfunction

endpackage

>>> rtl/core/lpk_front.sv
`timescale 1ns / 1ps
// lpk_front: per-particle compare and update of the four kept entries
// depends on lpk_pkg
module lpk_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  lpk_pkg::particle_t      particle,
    output logic                    snap_push,
    output lpk_pkg::event_snap_t    snap
);
    import lpk_pkg::*;

    class_entry_t [NUM_CLASSES-1:0] class_reg;
    class_entry_t [NUM_CLASSES-1:0] class_next;
    logic [31:0]                    code_mag;
    logic [NUM_CLASSES-1:0]         hit;

    assign code_mag = mag32(particle.particle_code);

    always_comb
    begin
        hit = '0;
        hit[CLS_ANY] = 1'b1;
        if (code_mag == CODE_ELECTRON)
            hit[CLS_ELECTRON] = 1'b1;
        else if (code_mag == CODE_MUON)
            hit[CLS_MUON] = 1'b1;
        else if (code_mag == CODE_PHOTON)
            hit[CLS_PHOTON] = 1'b1;
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            class_next[c] = class_reg[c];
            // strictly greater replaces, first of equal energies stays
            if (hit[c] && (!class_reg[c].valid || particle.energy > class_reg[c].energy))
            begin
                class_next[c].valid  = 1'b1;
                class_next[c].energy = particle.energy;
                class_next[c].mom_x  = particle.mom_x;
                class_next[c].mom_y  = particle.mom_y;
                class_next[c].mom_z  = particle.mom_z;
                class_next[c].code   = particle.particle_code;
            end
        end
    end

    assign snap_push = accept && particle.last_of_event;
    assign snap      = class_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
                class_reg[c].valid <= 1'b0;
        end
        else if (accept)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                class_reg[c] <= class_next[c];
                if (particle.last_of_event)
                    class_reg[c].valid <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/core/lpk_evq.sv
`timescale 1ns / 1ps
// lpk_evq: two-entry queue of finished event snapshots between front and back
// depends on lpk_pkg
module lpk_evq (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr,
    input  lpk_pkg::event_snap_t    wr_data,
    output logic                    is_full,
    input  logic                    rd,
    output logic                    rd_valid,
    output lpk_pkg::event_snap_t    rd_data
);
    import lpk_pkg::*;

    event_snap_t [1:0] mem_reg;
    logic              wp_reg;
    logic              rp_reg;
    logic [1:0]        cnt_reg;

    assign is_full  = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
                wp_reg <= ~wp_reg;
            if (rd)
                rp_reg <= ~rp_reg;
            if (wr && !rd)
                cnt_reg <= cnt_reg + 2'd1;
            else if (rd && !wr)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

>>> rtl/core/lpk_back.sv
`timescale 1ns / 1ps
// lpk_back: per-class kinematics sequencer (squares, two square roots, division)
// and the result output register; depends on lpk_pkg
module lpk_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    snap_valid,
    input  lpk_pkg::event_snap_t    snap,
    output logic                    snap_pop,
    output logic                    empty,
    input  logic                    pop,
    output lpk_pkg::result_t        result
);
    import lpk_pkg::*;

    back_state_t state_reg, state_next;
    logic [CLS_W-1:0] cls_reg;
    logic [4:0]       cnt_reg;
    logic [63:0]      sqx_reg, sqy_reg, sqz_reg, sxy_reg;
    logic [63:0]      rem_reg, root_reg, bit_reg;
    logic [31:0]      pt_reg, p_reg;
    logic [33:0]      drem_reg;
    logic [14:0]      q_reg;
    logic             out_valid_reg;
    result_t          out_reg;

    class_entry_t     ent;
    logic [31:0]      mul_op;
    logic [63:0]      mul_res;
    logic [63:0]      test;
    logic             take;
    logic             emit_load;
    logic             out_free;
    logic [14:0]      q_sat;
    logic signed [15:0] cos_val;

    assign ent      = snap[cls_reg];
    assign out_free = !out_valid_reg;

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    mul_op = mag32(ent.mom_x);
            2'd1:    mul_op = mag32(ent.mom_y);
            default: mul_op = mag32(ent.mom_z);
        endcase
    end

    assign mul_res = 64'(mul_op) * 64'(mul_op);
    assign test    = root_reg + bit_reg;
    assign take    = (rem_reg >= test);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
                if (snap_valid)
                    state_next = ent.valid ? B_MUL : B_EMIT;
            B_MUL:
                if (cnt_reg == 5'd2)
                    state_next = B_PT_INIT;
            B_PT_INIT:
                state_next = B_PT_STEP;
            B_PT_STEP:
                if (cnt_reg == 5'd31)
                    state_next = B_P_INIT;
            B_P_INIT:
                state_next = B_P_STEP;
            B_P_STEP:
                if (cnt_reg == 5'd31)
                    state_next = B_DIV_INIT;
            B_DIV_INIT:
                state_next = B_DIV_STEP;
            B_DIV_STEP:
                if (cnt_reg == 5'd14)
                    state_next = B_EMIT;
            B_EMIT:
                if (out_free)
                    state_next = B_IDLE;
            default:
                state_next = B_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        emit_load = 1'b0;
        snap_pop  = 1'b0;
        case (state_reg)
            B_EMIT:
            begin
                emit_load = out_free;
                snap_pop  = out_free && (cls_reg == CLS_ANY);
            end
            default:
            begin
                emit_load = 1'b0;
                snap_pop  = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        q_sat = (q_reg > 15'(COS_ONE)) ? 15'(COS_ONE) : q_reg;
        if (p_reg == 32'd0)
            cos_val = '0;
        else if (ent.mom_z[31])
            cos_val = -$signed({1'b0, q_sat});
        else
            cos_val = $signed({1'b0, q_sat});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cls_reg       <= CLS_ELECTRON;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                B_IDLE:     cnt_reg <= '0;
                B_MUL:      cnt_reg <= (cnt_reg == 5'd2) ? 5'd0 : cnt_reg + 5'd1;
                B_PT_STEP,
                B_P_STEP,
                B_DIV_STEP: cnt_reg <= cnt_reg + 5'd1;
                default:    cnt_reg <= '0;
            endcase
            if (emit_load)
                cls_reg <= cls_reg + 2'd1;
            if (emit_load)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_MUL:
            begin
                case (cnt_reg[1:0])
                    2'd0:    sqx_reg <= mul_res;
                    2'd1:    sqy_reg <= mul_res;
                    default: sqz_reg <= mul_res;
                endcase
            end
            B_PT_INIT:
            begin
                sxy_reg  <= sqx_reg + sqy_reg;
                rem_reg  <= sqx_reg + sqy_reg;
                root_reg <= '0;
                bit_reg  <= 64'd1 << 62;
            end
            B_P_INIT:
            begin
                pt_reg   <= root_reg[31:0];
                rem_reg  <= sxy_reg + sqz_reg;
                root_reg <= '0;
                bit_reg  <= 64'd1 << 62;
            end
            B_PT_STEP,
            B_P_STEP:
            begin
                // one bit pair of the restoring square root
                if (take)
                begin
                    rem_reg  <= rem_reg - test;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                    root_reg <= root_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            B_DIV_INIT:
            begin
                p_reg    <= root_reg[31:0];
                drem_reg <= 34'(mag32(ent.mom_z));
                q_reg    <= '0;
            end
            B_DIV_STEP:
            begin
                // |pz| <= p so the quotient fits in 15 bits
                if (drem_reg >= 34'(p_reg))
                begin
                    drem_reg <= (drem_reg - 34'(p_reg)) << 1;
                    q_reg    <= {q_reg[13:0], 1'b1};
                end
                else
                begin
                    drem_reg <= drem_reg << 1;
                    q_reg    <= {q_reg[13:0], 1'b0};
                end
            end
            default:
            begin
            end
        endcase
        if (emit_load)
        begin
            out_reg.category    <= cls_reg;
            out_reg.found       <= ent.valid;
            out_reg.last_result <= (cls_reg == CLS_ANY);
            if (ent.valid)
            begin
                out_reg.best_energy_out     <= ent.energy;
                out_reg.total_momentum      <= p_reg;
                out_reg.transverse_momentum <= pt_reg;
                out_reg.cos_theta           <= cos_val;
                out_reg.code_out            <= ent.code;
            end
            else
            begin
                out_reg.best_energy_out     <= '0;
                out_reg.total_momentum      <= '0;
                out_reg.transverse_momentum <= '0;
                out_reg.cos_theta           <= '0;
                out_reg.code_out            <= '0;
            end
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule

>>> rtl/core/leading_particle_kinematics.sv
`timescale 1ns / 1ps
// leading_particle_kinematics: one particle beat per cycle while full is low,
// four result beats per event. throughput: front takes one particle each cycle unless full;
// full rises only while two events wait. back: per class with a particle, 3 squares, two
// 32-step roots and a 15-step divide in turn on the single shared multiplier and root/divide
// unit; an empty class goes straight to emit.
// reset: asynchronous, clears the kept-entry valid flags, the event queue and the output valid flag.
module leading_particle_kinematics (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  lpk_pkg::particle_t  particle,
    output logic                empty,
    input  logic                pop,
    output lpk_pkg::result_t    result
);
    import lpk_pkg::*;

    logic        accept;
    logic        snap_push;
    event_snap_t snap_in;
    event_snap_t snap_out;
    logic        snap_valid;
    logic        snap_pop;

    assign accept = push && !full;

    lpk_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .particle  (particle),
        .snap_push (snap_push),
        .snap      (snap_in)
    );

    lpk_evq u_evq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (snap_push),
        .wr_data  (snap_in),
        .is_full  (full),
        .rd       (snap_pop),
        .rd_valid (snap_valid),
        .rd_data  (snap_out)
    );

    lpk_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap       (snap_out),
        .snap_pop   (snap_pop),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

>>> rtl/core/lpk_checker.sv
`timescale 1ns / 1ps
// lpk_checker: port-level checks on the result side of leading_particle_kinematics
// depends on lpk_pkg; bound to the top level below
module lpk_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                empty,
    input  logic                pop,
    input  lpk_pkg::result_t    result
);
    import lpk_pkg::*;

    a_last_on_any: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.last_result == (result.category == CLS_ANY)))
        else $error("last_result does not match the any-particle class");

    a_empty_class_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.found) |-> (result.best_energy_out == 32'd0 &&
            result.code_out == 32'sd0 && result.cos_theta == 16'sd0))
        else $error("class without a particle carries nonzero fields");

    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.cos_theta <= COS_ONE && result.cos_theta >= COS_NEG_ONE))
        else $error("cos theta out of range");

    a_zero_mom_cos: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.total_momentum == 32'd0) |-> (result.cos_theta == 16'sd0))
        else $error("cos theta nonzero with zero momentum");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result beat changed");

endmodule

bind leading_particle_kinematics lpk_checker u_lpk_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
